### hw/rtl/oate_pkg.sv
// ----------------------------------------------------------------------------
// oate_pkg
// Shared constants, command and status codes and the word types of the
// ordered array table engine.
// ----------------------------------------------------------------------------
package oate_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = 7;
	localparam int POS_W       = 7;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_UPDATE = 3'd2;
	localparam logic [2:0] CMD_DELETE = 3'd3;
	localparam logic [2:0] CMD_SORT   = 3'd4;
	localparam logic [2:0] CMD_SEARCH = 3'd5;
	localparam logic [2:0] CMD_DUMP   = 3'd6;
	localparam logic [2:0] CMD_SPARE  = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADPOS  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [2:0]                    command;
		logic [POS_W-1:0]              position;
		logic signed [VALUE_WIDTH-1:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [1:0]                    status;
		logic                          found;
		logic [5:0]                    result_index;
		logic signed [VALUE_WIDTH-1:0] result_value;
		logic [CNT_W-1:0]              entry_count;
		logic                          last;
	} rsp_t;

endpackage

### hw/rtl/ordered_array_table_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// Packed table of signed entries with a fill count: clear, insert, update,
// delete, exchange sort, search and dump, all run out of one synchronous RAM.
// ----------------------------------------------------------------------------
//
// channel   | handshake                      | word
// ----------+--------------------------------+----------------------------
// command   | start, taken when busy is low  | req  (oate_pkg::req_t)
// result    | rsp_valid, one cycle, no stall | rsp  (oate_pkg::rsp_t)
//
// Clear, update, rejected commands and the unused code go straight to the
// single result. Insert and delete walk each moved entry; search and dump
// walk every entry; sort of n >= 2 entries compares every pair. The single
// RAM read port with its registered read sets the pace of every walk.
// Reset clears the fill count, the sequencer and rsp_valid only; the RAM holds
// garbage until written, and only entries below the fill count are ever used.
// Results cannot be stalled: each one shows for exactly one cycle.
module ordered_array_table_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  oate_pkg::req_t  req,
	output logic            rsp_valid,
	output oate_pkg::rsp_t  rsp
);

	localparam int IW = oate_pkg::IDX_W;
	localparam int CW = oate_pkg::CNT_W;
	localparam int VW = oate_pkg::VALUE_WIDTH;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;  // walk: check bounds, issue read
	localparam logic [3:0] S_EX   = 4'd2;  // walk: use read data
	localparam logic [3:0] S_SA   = 4'd3;  // sort: read outer entry
	localparam logic [3:0] S_SB   = 4'd4;  // sort: latch outer entry
	localparam logic [3:0] S_SC   = 4'd5;  // sort: read inner entry
	localparam logic [3:0] S_SD   = 4'd6;  // sort: compare, maybe swap
	localparam logic [3:0] S_SE   = 4'd7;  // sort: write back outer entry
	localparam logic [3:0] S_FIN  = 4'd8;  // single result

	logic [3:0]     state_q;
	logic [2:0]     op_q;
	logic [CW-1:0]  pos_q;
	logic [VW-1:0]  val_q;
	logic [1:0]     stat_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;
	logic [IW-1:0]  i_q;
	logic [IW-1:0]  j_q;
	logic [VW-1:0]  a_q;
	logic           match_q;
	logic [IW-1:0]  pend_q;

	// table RAM
	logic [VW-1:0]  mem [oate_pkg::CAPACITY];
	logic [VW-1:0]  rdata_q;
	logic [IW-1:0]  raddr;
	logic           we;
	logic [IW-1:0]  waddr;
	logic [VW-1:0]  wdata;

	logic           accept;
	logic           swap;
	logic [CW-1:0]  idx_p1;
	logic [CW-1:0]  j_p1;
	logic [CW-1:0]  i_p2;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign swap   = $signed(a_q) > $signed(rdata_q);
	assign idx_p1 = idx_q + CW'(1);
	assign j_p1   = {1'b0, j_q} + CW'(1);
	assign i_p2   = {1'b0, i_q} + CW'(2);

	// address and write selection
	always_comb begin
		raddr = idx_q[IW-1:0];
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata_q;
		case (state_q)
			S_IDLE: begin
				// update writes in place on acceptance
				if (accept && req.command == oate_pkg::CMD_UPDATE
						&& req.position < count_q) begin
					we    = 1'b1;
					waddr = req.position[IW-1:0];
					wdata = req.entry_value;
				end
			end
			S_RD: begin
				if (op_q == oate_pkg::CMD_INSERT) begin
					raddr = IW'(idx_q - CW'(1));
					if (idx_q <= pos_q) begin
						we    = 1'b1;
						waddr = pos_q[IW-1:0];
						wdata = val_q;
					end
				end else if (op_q == oate_pkg::CMD_DELETE) begin
					raddr = idx_p1[IW-1:0];
				end
			end
			S_EX: begin
				if (op_q == oate_pkg::CMD_INSERT || op_q == oate_pkg::CMD_DELETE) begin
					we = 1'b1;
				end
			end
			S_SA: raddr = i_q;
			S_SC: raddr = j_q;
			S_SD: begin
				raddr = j_q;
				we    = swap;
				waddr = j_q;
				wdata = a_q;
			end
			S_SE: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= req.command;
						pos_q   <= req.position;
						val_q   <= req.entry_value;
						stat_q  <= oate_pkg::ST_OK;
						idx_q   <= '0;
						i_q     <= '0;
						match_q <= 1'b0;
						state_q <= S_FIN;
						case (req.command)
							oate_pkg::CMD_CLEAR: count_q <= '0;
							oate_pkg::CMD_INSERT: begin
								if (req.position > count_q) begin
									stat_q <= oate_pkg::ST_BADPOS;
								end else if (count_q == CW'(oate_pkg::CAPACITY)) begin
									stat_q <= oate_pkg::ST_FULL;
								end else begin
									idx_q   <= count_q;
									state_q <= S_RD;
								end
							end
							oate_pkg::CMD_UPDATE: begin
								if (req.position >= count_q) begin
									stat_q <= oate_pkg::ST_BADPOS;
								end
							end
							oate_pkg::CMD_DELETE: begin
								if (req.position >= count_q) begin
									stat_q <= oate_pkg::ST_BADPOS;
								end else begin
									idx_q   <= req.position;
									state_q <= S_RD;
								end
							end
							oate_pkg::CMD_SORT: begin
								if (count_q >= CW'(2)) begin
									state_q <= S_SA;
								end
							end
							oate_pkg::CMD_SEARCH: state_q <= S_RD;
							oate_pkg::CMD_DUMP: begin
								if (count_q != '0) begin
									state_q <= S_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EX;
					case (op_q)
						oate_pkg::CMD_INSERT: begin
							if (idx_q <= pos_q) begin
								// slot is open: value written above, close out
								count_q   <= count_q + CW'(1);
								rsp_valid <= 1'b1;
								rsp       <= '{oate_pkg::ST_OK, 1'b0, 6'd0, '0,
									count_q + CW'(1), 1'b1};
								state_q   <= S_IDLE;
							end
						end
						oate_pkg::CMD_DELETE: begin
							if (idx_p1 >= count_q) begin
								count_q   <= count_q - CW'(1);
								rsp_valid <= 1'b1;
								rsp       <= '{oate_pkg::ST_OK, 1'b0, 6'd0, '0,
									count_q - CW'(1), 1'b1};
								state_q   <= S_IDLE;
							end
						end
						default: begin
							// search and dump walk all entries
							if (idx_q >= count_q) begin
								state_q   <= S_IDLE;
								rsp_valid <= 1'b1;
								rsp       <= '{oate_pkg::ST_OK, match_q,
									match_q ? 6'(pend_q) : 6'd0, val_q, count_q, 1'b1};
							end
						end
					endcase
				end
				S_EX: begin
					state_q <= S_RD;
					case (op_q)
						oate_pkg::CMD_INSERT: idx_q <= idx_q - CW'(1);
						oate_pkg::CMD_DELETE: idx_q <= idx_p1;
						oate_pkg::CMD_SEARCH: begin
							idx_q <= idx_p1;
							if (rdata_q == val_q) begin
								// hold this match, release the one before it
								match_q <= 1'b1;
								pend_q  <= idx_q[IW-1:0];
								if (match_q) begin
									rsp_valid <= 1'b1;
									rsp       <= '{oate_pkg::ST_OK, 1'b1, 6'(pend_q),
										val_q, count_q, 1'b0};
								end
							end
						end
						default: begin
							idx_q     <= idx_p1;
							rsp_valid <= 1'b1;
							rsp       <= '{oate_pkg::ST_OK, 1'b0, 6'(idx_q[IW-1:0]),
								rdata_q, count_q, idx_p1 == count_q};
							if (idx_p1 == count_q) begin
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_SA: state_q <= S_SB;
				S_SB: begin
					a_q     <= rdata_q;
					j_q     <= i_q + IW'(1);
					state_q <= S_SC;
				end
				S_SC: state_q <= S_SD;
				S_SD: begin
					if (swap) begin
						a_q <= rdata_q;
					end
					j_q     <= j_q + IW'(1);
					state_q <= (j_p1 < count_q) ? S_SC : S_SE;
				end
				S_SE: begin
					i_q <= i_q + IW'(1);
					if (i_p2 < count_q) begin
						state_q <= S_SA;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q   <= S_IDLE;
					rsp_valid <= 1'b1;
					rsp       <= '{stat_q, 1'b0, 6'd0, '0, count_q, 1'b1};
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/oate_chk.sv
// ----------------------------------------------------------------------------
// oate_chk
// Port-level checks of the ordered array table engine, bound to the top level.
// ----------------------------------------------------------------------------
module oate_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           rsp_valid,
	input oate_pkg::rsp_t rsp
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("command taken but engine idle");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> !busy) else $error("last word while busy");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> busy) else $error("non-last word while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= 7'(oate_pkg::CAPACITY))
		else $error("entry count beyond capacity");

endmodule

bind ordered_array_table_engine oate_chk u_oate_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered array table engine: a shadow table
// predicts every result word of each command, a monitor compares each strobed
// word with the oldest prediction, and named tests cover the corner cases and
// a long random mix of load, edit, sort, search and dump sequences.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	oate_pkg::req_t req;
	logic rsp_valid;
	oate_pkg::rsp_t rsp;

	ordered_array_table_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	// Shadow table: mirrors the block's store and fill count.
	logic signed [oate_pkg::VALUE_WIDTH-1:0] shadow_table [oate_pkg::CAPACITY];
	int   shadow_count;
	oate_pkg::rsp_t pending_words [$];
	int   mismatch_count;
	int   idle_cycles;
	bit   timed_out;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic oate_pkg::rsp_t make_word(logic [1:0] st, logic fnd, int idx,
			logic signed [oate_pkg::VALUE_WIDTH-1:0] v, logic lst);
		oate_pkg::rsp_t w;
		w.status       = st;
		w.found        = fnd;
		w.result_index = idx[5:0];
		w.result_value = v;
		w.entry_count  = shadow_count[oate_pkg::CNT_W-1:0];
		w.last         = lst;
		return w;
	endfunction

	// Apply one command to the shadow table and queue the words it yields.
	task automatic predict_command(oate_pkg::req_t r);
		logic [1:0] st;
		int pos;
		int hits;
		logic signed [oate_pkg::VALUE_WIDTH-1:0] t;
		st  = oate_pkg::ST_OK;
		pos = r.position;
		hits = 0;
		case (r.command)
			oate_pkg::CMD_CLEAR: shadow_count = 0;
			oate_pkg::CMD_INSERT: begin
				if (pos > shadow_count) st = oate_pkg::ST_BADPOS;
				else if (shadow_count >= oate_pkg::CAPACITY) st = oate_pkg::ST_FULL;
				else begin
					for (int i = shadow_count; i > pos; i--)
						shadow_table[i] = shadow_table[i-1];
					shadow_table[pos] = r.entry_value;
					shadow_count++;
				end
			end
			oate_pkg::CMD_UPDATE: begin
				if (pos >= shadow_count) st = oate_pkg::ST_BADPOS;
				else shadow_table[pos] = r.entry_value;
			end
			oate_pkg::CMD_DELETE: begin
				if (pos >= shadow_count) st = oate_pkg::ST_BADPOS;
				else begin
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_table[i] = shadow_table[i+1];
					shadow_count--;
				end
			end
			oate_pkg::CMD_SORT: begin
				for (int i = 0; i + 1 < shadow_count; i++)
					for (int j = i + 1; j < shadow_count; j++)
						if (shadow_table[i] > shadow_table[j]) begin
							t = shadow_table[i];
							shadow_table[i] = shadow_table[j];
							shadow_table[j] = t;
						end
			end
			oate_pkg::CMD_SEARCH: begin
				for (int i = 0; i < shadow_count; i++)
					if (shadow_table[i] == r.entry_value) begin
						pending_words.push_back(make_word(oate_pkg::ST_OK, 1'b1, i,
							r.entry_value, 1'b0));
						hits++;
					end
				if (hits == 0)
					pending_words.push_back(make_word(oate_pkg::ST_OK, 1'b0, 0,
						r.entry_value, 1'b1));
				else
					pending_words[$].last = 1'b1;
				return;
			end
			oate_pkg::CMD_DUMP: begin
				if (shadow_count == 0)
					pending_words.push_back(make_word(oate_pkg::ST_OK, 1'b0, 0, '0, 1'b1));
				for (int i = 0; i < shadow_count; i++)
					pending_words.push_back(make_word(oate_pkg::ST_OK, 1'b0, i,
						shadow_table[i], i + 1 == shadow_count));
				return;
			end
			default: ;
		endcase
		pending_words.push_back(make_word(st, 1'b0, 0, '0, 1'b1));
	endtask

	// Send one word after a random gap; predict it when it is taken.
	task automatic send_word(logic [2:0] cmd, int pos,
			logic signed [oate_pkg::VALUE_WIDTH-1:0] v);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		req.command     <= cmd;
		req.position    <= pos[oate_pkg::POS_W-1:0];
		req.entry_value <= v;
		do @(posedge clk); while (busy);
		predict_command(req);
		start <= 1'b0;
		// the block is busy on the next edge anyway; step past it
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Monitor: compare each strobed word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid) begin
			if (pending_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word %p", rsp);
			end else begin
				if (rsp !== pending_words[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %p actual %p",
							pending_words[0], rsp);
				end
				void'(pending_words.pop_front());
			end
		end
	end

	// Watchdog: count cycles with no word moving either way.
	always @(posedge clk) begin
		if ((start && !busy) || rsp_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
	end

	function automatic logic signed [oate_pkg::VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return -1;
			4: return $urandom;
			default: return $signed($urandom_range(0, 7)) - 3;
		endcase
	endfunction

	task automatic test_corners();
		send_word(oate_pkg::CMD_DUMP, 0, 0);
		send_word(oate_pkg::CMD_SEARCH, 0, 5);
		send_word(oate_pkg::CMD_SORT, 0, 0);
		send_word(oate_pkg::CMD_INSERT, 1, 9);
		send_word(oate_pkg::CMD_UPDATE, 0, 1);
		send_word(oate_pkg::CMD_DELETE, 0, 1);
		send_word(oate_pkg::CMD_INSERT, 0, 32'sh7fffffff);
		send_word(oate_pkg::CMD_INSERT, 0, 32'sh80000000);
		send_word(oate_pkg::CMD_INSERT, 2, -1);
		send_word(oate_pkg::CMD_INSERT, 1, -1);
		send_word(oate_pkg::CMD_UPDATE, 3, 0);
		send_word(oate_pkg::CMD_UPDATE, 127, 0);
		send_word(oate_pkg::CMD_INSERT, 127, 0);
		send_word(oate_pkg::CMD_DELETE, 4, 0);
		send_word(oate_pkg::CMD_SEARCH, 0, -1);
		send_word(oate_pkg::CMD_SEARCH, 0, 42);
		send_word(oate_pkg::CMD_SORT, 0, 0);
		send_word(oate_pkg::CMD_DUMP, 0, 0);
		send_word(oate_pkg::CMD_SPARE, 85, 32'sh55aa55aa);
		send_word(oate_pkg::CMD_DELETE, 0, 0);
		send_word(oate_pkg::CMD_DUMP, 0, 0);
		send_word(oate_pkg::CMD_CLEAR, 0, 0);
		send_word(oate_pkg::CMD_DUMP, 0, 0);
	endtask

	// Fill to capacity, then hit the full status and walk the whole table.
	task automatic test_full_store();
		send_word(oate_pkg::CMD_CLEAR, 0, 0);
		for (int i = 0; i < oate_pkg::CAPACITY; i++)
			send_word(oate_pkg::CMD_INSERT, $urandom_range(0, i), pick_value());
		send_word(oate_pkg::CMD_INSERT, 0, 1);
		send_word(oate_pkg::CMD_INSERT, oate_pkg::CAPACITY, 1);
		send_word(oate_pkg::CMD_INSERT, oate_pkg::CAPACITY + 1, 1);
		send_word(oate_pkg::CMD_SORT, 0, 0);
		send_word(oate_pkg::CMD_DUMP, 0, 0);
		send_word(oate_pkg::CMD_DELETE, oate_pkg::CAPACITY - 1, 0);
		send_word(oate_pkg::CMD_DELETE, 0, 0);
		send_word(oate_pkg::CMD_SEARCH, 0, shadow_table[0]);
		wait_drained();
	endtask

	// Random sequences: small loads with edits, sorts, searches and noise.
	task automatic test_random_mix();
		int n;
		int pos;
		logic [2:0] cmd;
		for (int s = 0; s < 20; s++) begin
			send_word(oate_pkg::CMD_CLEAR, $urandom_range(0, 127), $urandom);
			n = $urandom_range(0, 12);
			for (int i = 0; i < n; i++)
				send_word(oate_pkg::CMD_INSERT, $urandom_range(0, shadow_count),
					pick_value());
			for (int k = 0; k < 6; k++) begin
				cmd = 3'($urandom_range(0, 7));
				if ($urandom_range(0, 4) == 0) pos = $urandom_range(0, 127);
				else pos = $urandom_range(0, shadow_count);
				if (cmd == oate_pkg::CMD_SEARCH && shadow_count > 0 && $urandom_range(0, 1))
					send_word(cmd, pos, shadow_table[$urandom_range(0, shadow_count - 1)]);
				else
					send_word(cmd, pos, pick_value());
			end
			if (s == 12) wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		shadow_count = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		for (int i = 0; i < oate_pkg::CAPACITY; i++) shadow_table[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_full_store();
		test_random_mix();
		wait_drained();
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("ordered_array_table_engine verification clean");
		else
			$display("ordered_array_table_engine verification failed");
		$finish;
	end

	initial begin
		wait (timed_out);
		$display("ordered_array_table_engine verification failed");
		$finish;
	end

endmodule
